/* rtl/mief_pkg.sv */
// Shared types, constants and a helper function of the MPLS ICMP echo frame builder.
package mief_pkg;

	localparam int CFG_DATA_W = 60;
	localparam int CFG_IDX_W  = 3;
	localparam int LABEL_W    = 20;

	localparam logic [15:0] ETHERTYPE_MPLS = 16'h8847;
	localparam logic [7:0]  HOP_TTL        = 8'h40;
	localparam logic [15:0] IP_ID_BASE     = 16'h4000;
	localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
	localparam logic [15:0] IP_TTL_PROTO   = 16'h4001;
	localparam logic [15:0] ICMP_TYPE_CODE = 16'h0800;
	localparam logic [7:0]  FILL_BASE      = 8'h10;
	localparam int          ETH_WORDS      = 7;
	localparam int          IP_ICMP_WORDS  = 14;
	localparam int          HDR_LEN_IP_ICMP = 28;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NEXT_HOP_MAC = 3'd0,
		CFG_OWN_MAC      = 3'd1,
		CFG_SOURCE_IP    = 3'd2,
		CFG_TARGET_IP    = 3'd3,
		CFG_ECHO_IDENT   = 3'd4,
		CFG_STACK_DEPTH  = 3'd5,
		CFG_LABEL_STACK  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [47:0] next_hop_mac;
		logic [47:0] own_mac;
		logic [31:0] source_ip;
		logic [31:0] target_ip;
		logic [15:0] echo_ident;
		logic [1:0]  stack_depth;
		logic [59:0] label_stack;
	} cfg_t;

	// One probe as handed from the front to the back.
	typedef struct packed {
		logic [15:0] seq;
		logic [63:0] send_time;
		logic [15:0] ip_ck;
		logic [15:0] icmp_ck;
	} desc_t;

	// Folded 16-bit sum of the constant filler bytes of the payload.
	function automatic logic [15:0] fill_sum(input int payload_bytes);
		int acc;
		acc = 0;
		for (int i = 8; i < payload_bytes; i++) begin
			if ((i & 1) == 0)
				acc = acc + ((16 + i) << 8);
			else
				acc = acc + (16 + i);
		end
		acc = (acc & 32'hFFFF) + (acc >> 16);
		acc = (acc & 32'hFFFF) + (acc >> 16);
		return 16'(acc);
	endfunction

endpackage

/* rtl/mief_if.sv */
// Handshake channel interfaces for timestamps, frame words and register writes.
interface mief_ts_if;
	logic        valid;
	logic        ready;
	logic [63:0] send_time;
	modport source (output valid, output send_time, input ready);
	modport sink (input valid, input send_time, output ready);
endinterface

interface mief_fw_if;
	logic        valid;
	logic        ready;
	logic [15:0] frame_word;
	logic        is_last;
	modport source (output valid, output frame_word, output is_last, input ready);
	modport sink (input valid, input frame_word, input is_last, output ready);
endinterface

interface mief_cfg_if import mief_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/mief_front.sv */
// Front end: accepts timestamps, advances the sequence and works out both checksums.
module mief_front import mief_pkg::*; #(
	parameter int PAYLOAD_BYTES = 56
) (
	input  logic  clk,
	input  logic  arst_n,
	mief_ts_if.sink probe,
	input  cfg_t  cfg,
	input  logic  q_full,
	output logic  push,
	output desc_t push_desc
);

	localparam logic [15:0] TOT_LEN  = 16'(HDR_LEN_IP_ICMP + PAYLOAD_BYTES);
	localparam logic [15:0] FILL_SUM = fill_sum(PAYLOAD_BYTES);

	logic [15:0] seq_q;
	logic [15:0] seq_next;
	logic        valid_s1, valid_s2;
	logic [15:0] seq_s1;
	logic [63:0] time_s1;
	logic [19:0] ip_raw_s1, icmp_raw_s1;
	desc_t       desc_s2;
	logic        adv1, adv2, accept;
	logic [19:0] ip_raw, icmp_raw;
	logic [16:0] ip_a, icmp_a;
	logic [15:0] ip_b, icmp_b;
	logic [63:0] t;

	assign adv2        = !valid_s2 || !q_full;
	assign adv1        = !valid_s1 || adv2;
	assign probe.ready = adv1;
	assign accept      = probe.valid && adv1;
	assign seq_next    = seq_q + 16'd1;
	assign t           = probe.send_time;

	always_comb begin
		ip_raw = 20'(IP_VER_IHL_TOS) + 20'(TOT_LEN) + 20'(IP_ID_BASE | seq_next)
			+ 20'(IP_ID_BASE) + 20'(IP_TTL_PROTO)
			+ 20'(cfg.source_ip[31:16]) + 20'(cfg.source_ip[15:0])
			+ 20'(cfg.target_ip[31:16]) + 20'(cfg.target_ip[15:0]);
		// The timestamp sits in the payload little-endian, so bytes swap within each word.
		icmp_raw = 20'(ICMP_TYPE_CODE) + 20'(cfg.echo_ident) + 20'(seq_next)
			+ 20'({t[7:0], t[15:8]}) + 20'({t[23:16], t[31:24]})
			+ 20'({t[39:32], t[47:40]}) + 20'({t[55:48], t[63:56]})
			+ 20'(FILL_SUM);
		ip_a   = 17'(ip_raw_s1[15:0]) + 17'(ip_raw_s1[19:16]);
		ip_b   = ip_a[15:0] + 16'(ip_a[16]);
		icmp_a = 17'(icmp_raw_s1[15:0]) + 17'(icmp_raw_s1[19:16]);
		icmp_b = icmp_a[15:0] + 16'(icmp_a[16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept)
				seq_q <= seq_next;
			if (adv1)
				valid_s1 <= accept;
			if (adv2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seq_s1      <= seq_next;
			time_s1     <= probe.send_time;
			ip_raw_s1   <= ip_raw;
			icmp_raw_s1 <= icmp_raw;
		end
		if (adv2 && valid_s1) begin
			desc_s2.seq       <= seq_s1;
			desc_s2.send_time <= time_s1;
			desc_s2.ip_ck     <= ~ip_b;
			desc_s2.icmp_ck   <= ~icmp_b;
		end
	end

	assign push      = valid_s2 && !q_full;
	assign push_desc = desc_s2;

endmodule

/* rtl/mief_queue.sv */
// Two-entry queue of probe descriptors between the front and back ends.
module mief_queue import mief_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output desc_t head_desc
);

	desc_t      entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head_desc  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_desc;
	end

endmodule

/* rtl/mief_back.sv */
// Back end: emits registered 16-bit frame words, one a cycle unless stalled.
module mief_back import mief_pkg::*; #(
	parameter int MAX_LABELS    = 3,
	parameter int PAYLOAD_BYTES = 56
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  head_valid,
	input  desc_t head_desc,
	output logic  pop,
	mief_fw_if.source frame
);

	localparam int PAY_WORDS = (PAYLOAD_BYTES + 1) / 2;
	localparam int WORDS_MAX = ETH_WORDS + 2 * MAX_LABELS + IP_ICMP_WORDS + PAY_WORDS;
	localparam int WC_W      = $clog2(WORDS_MAX);
	localparam logic [15:0] TOT_LEN = 16'(HDR_LEN_IP_ICMP + PAYLOAD_BYTES);
	localparam logic        PAY_ODD = (PAYLOAD_BYTES % 2) != 0;

	logic [WC_W-1:0]    w_q;
	logic               out_valid_q;
	logic [15:0]        frame_word_q;
	logic               is_last_q;
	logic [1:0]         nl;
	logic [WC_W-1:0]    hdr_words, words_total, r, lw, m;
	logic [1:0]         k;
	logic [LABEL_W-1:0] lab;
	logic               bos, last, load;
	logic [7:0]         fill_hi, fill_lo;
	logic [15:0]        word;
	logic [63:0]        t;

	always_comb begin
		// A zero count means one label; counts beyond the build limit saturate.
		if (cfg.stack_depth == 2'd0)
			nl = 2'd1;
		else if (32'(cfg.stack_depth) > MAX_LABELS)
			nl = 2'(MAX_LABELS);
		else
			nl = cfg.stack_depth;
		hdr_words   = WC_W'(ETH_WORDS) + WC_W'({nl, 1'b0});
		words_total = hdr_words + WC_W'(IP_ICMP_WORDS + PAY_WORDS);
		last        = w_q == words_total - WC_W'(1);
		r           = w_q - hdr_words;
		lw          = w_q - WC_W'(ETH_WORDS);
		k           = lw[2:1];
		m           = r - WC_W'(IP_ICMP_WORDS);
		bos         = k == nl - 2'd1;
		t           = head_desc.send_time;
		case (k)
			2'd1:    lab = cfg.label_stack[2*LABEL_W-1:LABEL_W];
			2'd2:    lab = cfg.label_stack[3*LABEL_W-1:2*LABEL_W];
			default: lab = cfg.label_stack[LABEL_W-1:0];
		endcase
		fill_hi = FILL_BASE + 8'({m, 1'b0});
		fill_lo = (last && PAY_ODD) ? 8'h00 : fill_hi + 8'h01;

		if (w_q < hdr_words) begin
			case (w_q)
				WC_W'(0): word = cfg.next_hop_mac[47:32];
				WC_W'(1): word = cfg.next_hop_mac[31:16];
				WC_W'(2): word = cfg.next_hop_mac[15:0];
				WC_W'(3): word = cfg.own_mac[47:32];
				WC_W'(4): word = cfg.own_mac[31:16];
				WC_W'(5): word = cfg.own_mac[15:0];
				WC_W'(6): word = ETHERTYPE_MPLS;
				default: begin
					if (!lw[0])
						word = lab[19:4];
					else
						word = {lab[3:0], 3'b000, bos, HOP_TTL};
				end
			endcase
		end else begin
			case (r)
				WC_W'(0):  word = IP_VER_IHL_TOS;
				WC_W'(1):  word = TOT_LEN;
				WC_W'(2):  word = IP_ID_BASE | head_desc.seq;
				WC_W'(3):  word = IP_ID_BASE;
				WC_W'(4):  word = IP_TTL_PROTO;
				WC_W'(5):  word = head_desc.ip_ck;
				WC_W'(6):  word = cfg.source_ip[31:16];
				WC_W'(7):  word = cfg.source_ip[15:0];
				WC_W'(8):  word = cfg.target_ip[31:16];
				WC_W'(9):  word = cfg.target_ip[15:0];
				WC_W'(10): word = ICMP_TYPE_CODE;
				WC_W'(11): word = head_desc.icmp_ck;
				WC_W'(12): word = cfg.echo_ident;
				WC_W'(13): word = head_desc.seq;
				WC_W'(14): word = {t[7:0], t[15:8]};
				WC_W'(15): word = {t[23:16], t[31:24]};
				WC_W'(16): word = {t[39:32], t[47:40]};
				WC_W'(17): word = {t[55:48], t[63:56]};
				default:   word = {fill_hi, fill_lo};
			endcase
		end
	end

	assign load = head_valid && (!out_valid_q || frame.ready);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				w_q <= last ? '0 : w_q + WC_W'(1);
			if (load)
				out_valid_q <= 1'b1;
			else if (frame.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_word_q <= word;
			is_last_q    <= last;
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.frame_word = frame_word_q;
	assign frame.is_last    = is_last_q;

endmodule

/* rtl/mpls_icmp_echo_frame_builder.sv */
// Top level of the MPLS ICMP echo frame builder: register file and the three parts.
//
// Each timestamp item on probe yields one MPLS-encapsulated ICMP echo request frame on
// frame, one 16-bit big-endian word per cycle while frame is ready, with is_last on the
// final word. A frame is 7 + 2*labels + 14 + ceil(PAYLOAD_BYTES/2) words (55 with three
// labels and 56 payload bytes), emitted by the back end's word sequencer. The front end
// computes both checksums in two pipeline stages and hands each probe to a two-entry queue
// whose head is the frame going out, so up to three further timestamps are taken while a
// frame is still being sent. The sequence number starts at 1 with the first probe.
// Write registers through cfg (always ready) only while idle; the block does not check.
module mpls_icmp_echo_frame_builder import mief_pkg::*; #(
	parameter int MAX_LABELS    = 3,
	parameter int PAYLOAD_BYTES = 56
) (
	input logic        clk,
	input logic        arst_n,
	mief_ts_if.sink    probe,
	mief_fw_if.source  frame,
	mief_cfg_if.sink   cfg
);

	cfg_t  cfg_q;
	logic  q_full, push, pop, head_valid;
	desc_t push_desc, head_desc;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// All registers clear except the label stack depth, which starts at one.
			cfg_q <= {48'd0, 48'd0, 32'd0, 32'd0, 16'd0, 2'd1, 60'd0};
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_NEXT_HOP_MAC: cfg_q.next_hop_mac <= cfg.data[47:0];
				CFG_OWN_MAC:      cfg_q.own_mac      <= cfg.data[47:0];
				CFG_SOURCE_IP:    cfg_q.source_ip    <= cfg.data[31:0];
				CFG_TARGET_IP:    cfg_q.target_ip    <= cfg.data[31:0];
				CFG_ECHO_IDENT:   cfg_q.echo_ident   <= cfg.data[15:0];
				CFG_STACK_DEPTH:  cfg_q.stack_depth  <= cfg.data[1:0];
				CFG_LABEL_STACK:  cfg_q.label_stack  <= cfg.data[59:0];
				default: ;
			endcase
		end
	end

	mief_front #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.probe     (probe),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	mief_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	mief_back #(
		.MAX_LABELS    (MAX_LABELS),
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (pop),
		.frame      (frame)
	);

endmodule

/* bench/tb_mpls_icmp_echo_frame_builder.sv */
// Self-checking testbench of the MPLS ICMP echo frame builder, with a frame predictor.
`timescale 1ns / 100ps

module tb_mpls_icmp_echo_frame_builder;
	import mief_pkg::*;

	localparam int MAX_LABELS    = 3;
	localparam int PAYLOAD_BYTES = 56;
	localparam int STALL_LIMIT   = 3000;
	localparam int LONG_HOLD     = 400;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 56;

	typedef struct packed {
		logic [15:0] word;
		logic        last;
	} frame_beat_t;

	logic clk;
	logic arst_n;

	mief_ts_if  probe_ch ();
	mief_fw_if  frame_ch ();
	mief_cfg_if cfg_ch ();

	mpls_icmp_echo_frame_builder #(
		.MAX_LABELS    (MAX_LABELS),
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.probe  (probe_ch),
		.frame  (frame_ch),
		.cfg    (cfg_ch)
	);

	// Register shadow and sequence counter of the predictor.
	logic [47:0] sh_next_hop;
	logic [47:0] sh_own_mac;
	logic [31:0] sh_source_ip;
	logic [31:0] sh_target_ip;
	logic [15:0] sh_ident;
	logic [1:0]  sh_stack_depth;
	logic [59:0] sh_label_stack;
	logic [15:0] probe_seq_model;

	logic [63:0] stamps_pending [$];
	frame_beat_t frame_words_due [$];
	frame_beat_t due_beat;

	int  fail_count;
	int  send_gap;
	int  sink_gap;
	int  hold_left;
	int  hold_requests;
	int  holds_taken;
	int  idle_cycles;
	bit  bursts_on;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [15:0] inet_checksum(input logic [7:0] b[$], input int from,
		input int len);
		logic [31:0] acc;
		acc = 32'd0;
		for (int i = 0; i + 1 < len; i += 2)
			acc += {16'd0, b[from + i], b[from + i + 1]};
		if (len % 2 != 0)
			acc += {16'd0, b[from + len - 1], 8'h00};
		while (acc[31:16] != 16'd0)
			acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
		return ~acc[15:0];
	endfunction

	// Works out the whole frame for one timestamp and queues its words.
	function automatic void build_echo_frame(input logic [63:0] stamp);
		logic [7:0]  fr [$];
		logic [31:0] lse;
		logic [15:0] hw;
		logic [15:0] ck;
		int          nl;
		int          ip_at;
		int          icmp_at;
		int          nwords;
		frame_beat_t beat;

		probe_seq_model = probe_seq_model + 16'd1;
		nl = (sh_stack_depth == 2'd0) ? 1 : int'(sh_stack_depth);
		if (nl > MAX_LABELS)
			nl = MAX_LABELS;

		for (int k = 5; k >= 0; k--)
			fr.push_back(sh_next_hop[8*k +: 8]);
		for (int k = 5; k >= 0; k--)
			fr.push_back(sh_own_mac[8*k +: 8]);
		fr.push_back(ETHERTYPE_MPLS[15:8]);
		fr.push_back(ETHERTYPE_MPLS[7:0]);
		for (int i = 0; i < nl; i++) begin
			lse = {sh_label_stack[LABEL_W*i +: LABEL_W], 3'b000, (i == nl - 1), HOP_TTL};
			for (int k = 3; k >= 0; k--)
				fr.push_back(lse[8*k +: 8]);
		end

		ip_at = fr.size();
		fr.push_back(8'h45);
		fr.push_back(8'h00);
		hw = 16'(20 + 8 + PAYLOAD_BYTES);
		fr.push_back(hw[15:8]);
		fr.push_back(hw[7:0]);
		hw = IP_ID_BASE | probe_seq_model;
		fr.push_back(hw[15:8]);
		fr.push_back(hw[7:0]);
		fr.push_back(IP_ID_BASE[15:8]);
		fr.push_back(IP_ID_BASE[7:0]);
		fr.push_back(HOP_TTL);
		fr.push_back(8'h01);
		fr.push_back(8'h00);
		fr.push_back(8'h00);
		for (int k = 3; k >= 0; k--)
			fr.push_back(sh_source_ip[8*k +: 8]);
		for (int k = 3; k >= 0; k--)
			fr.push_back(sh_target_ip[8*k +: 8]);
		ck = inet_checksum(fr, ip_at, 20);
		fr[ip_at + 10] = ck[15:8];
		fr[ip_at + 11] = ck[7:0];

		icmp_at = fr.size();
		fr.push_back(8'h08);
		fr.push_back(8'h00);
		fr.push_back(8'h00);
		fr.push_back(8'h00);
		fr.push_back(sh_ident[15:8]);
		fr.push_back(sh_ident[7:0]);
		fr.push_back(probe_seq_model[15:8]);
		fr.push_back(probe_seq_model[7:0]);
		// The timestamp goes in least significant byte first.
		for (int k = 0; k < 8; k++)
			fr.push_back(stamp[8*k +: 8]);
		for (int i = 8; i < PAYLOAD_BYTES; i++)
			fr.push_back(FILL_BASE + 8'(i));
		ck = inet_checksum(fr, icmp_at, 8 + PAYLOAD_BYTES);
		fr[icmp_at + 2] = ck[15:8];
		fr[icmp_at + 3] = ck[7:0];

		if (fr.size() % 2 != 0)
			fr.push_back(8'h00);
		nwords = fr.size() / 2;
		for (int i = 0; i < nwords; i++) begin
			beat.word = {fr[2*i], fr[2*i + 1]};
			beat.last = (i == nwords - 1);
			frame_words_due.push_back(beat);
		end
	endfunction

	// Sender of timestamp items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_ch.valid     <= 1'b0;
			probe_ch.send_time <= 64'd0;
			send_gap           <= 0;
		end else begin
			if (probe_ch.valid && probe_ch.ready)
				build_echo_frame(probe_ch.send_time);
			if (!probe_ch.valid || probe_ch.ready) begin
				if (send_gap != 0) begin
					send_gap       <= send_gap - 1;
					probe_ch.valid <= 1'b0;
				end else if (stamps_pending.size() == 0) begin
					probe_ch.valid <= 1'b0;
				end else if (bursts_on && $urandom_range(0, 7) == 0) begin
					send_gap       <= $urandom_range(0, 17);
					probe_ch.valid <= 1'b0;
				end else begin
					probe_ch.valid     <= 1'b1;
					probe_ch.send_time <= stamps_pending.pop_front();
				end
			end
		end
	end

	// Receiver of frame words, with the check against the predicted words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ch.ready <= 1'b0;
			sink_gap       <= 0;
			hold_left      <= 0;
			holds_taken    <= 0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				if (frame_words_due.size() == 0) begin
					$error("frame_word 0x%h (is_last %0b) arrived with nothing expected",
						frame_ch.frame_word, frame_ch.is_last);
					fail_count++;
				end else begin
					due_beat = frame_words_due.pop_front();
					if (frame_ch.frame_word !== due_beat.word) begin
						$error("frame_word: expected 0x%h, actual 0x%h",
							due_beat.word, frame_ch.frame_word);
						fail_count++;
					end
					if (frame_ch.is_last !== due_beat.last) begin
						$error("is_last: expected %0b, actual %0b",
							due_beat.last, frame_ch.is_last);
						fail_count++;
					end
				end
			end
			if (holds_taken < hold_requests && hold_left == 0) begin
				holds_taken    <= holds_taken + 1;
				hold_left      <= LONG_HOLD;
				frame_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left      <= hold_left - 1;
				frame_ch.ready <= 1'b0;
			end else if (sink_gap != 0) begin
				sink_gap       <= sink_gap - 1;
				frame_ch.ready <= 1'b0;
			end else if (bursts_on && $urandom_range(0, 7) == 0) begin
				sink_gap       <= $urandom_range(0, 17);
				frame_ch.ready <= 1'b0;
			end else begin
				frame_ch.ready <= 1'b1;
			end
		end
	end

	// Ends the run when no channel has moved an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((probe_ch.valid && probe_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Called just after a rising edge; returns at the edge that takes the write.
	task automatic write_reg(input cfg_idx_t idx, input logic [59:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			CFG_NEXT_HOP_MAC: sh_next_hop    = val[47:0];
			CFG_OWN_MAC:      sh_own_mac     = val[47:0];
			CFG_SOURCE_IP:    sh_source_ip   = val[31:0];
			CFG_TARGET_IP:    sh_target_ip   = val[31:0];
			CFG_ECHO_IDENT:   sh_ident       = val[15:0];
			CFG_STACK_DEPTH:  sh_stack_depth = val[1:0];
			CFG_LABEL_STACK:  sh_label_stack = val;
			default: ;
		endcase
	endtask

	task automatic write_all_regs(input logic [59:0] mac_a, input logic [59:0] mac_b,
		input logic [59:0] ip_a, input logic [59:0] ip_b, input logic [59:0] ident,
		input logic [59:0] labels_used, input logic [59:0] labels);
		write_reg(CFG_NEXT_HOP_MAC, mac_a);
		write_reg(CFG_OWN_MAC, mac_b);
		write_reg(CFG_SOURCE_IP, ip_a);
		write_reg(CFG_TARGET_IP, ip_b);
		write_reg(CFG_ECHO_IDENT, ident);
		write_reg(CFG_STACK_DEPTH, labels_used);
		write_reg(CFG_LABEL_STACK, labels);
		cfg_ch.valid <= 1'b0;
	endtask

	// Waits until every queued item has gone in and every frame word has come out.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (stamps_pending.size() != 0 || probe_ch.valid || frame_words_due.size() != 0);
	endtask

	function automatic logic [63:0] random_stamp();
		case ($urandom_range(0, 9))
			0:       return 64'd0;
			1:       return {64{1'b1}};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [59:0] random_word();
		return 60'({$urandom, $urandom});
	endfunction

	initial begin
		arst_n             = 1'b0;
		probe_ch.valid     = 1'b0;
		probe_ch.send_time = 64'd0;
		frame_ch.ready     = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = CFG_NEXT_HOP_MAC;
		cfg_ch.data        = '0;
		sh_next_hop        = '0;
		sh_own_mac         = '0;
		sh_source_ip       = '0;
		sh_target_ip       = '0;
		sh_ident           = '0;
		sh_stack_depth     = 2'd1;
		sh_label_stack     = '0;
		probe_seq_model    = '0;
		fail_count         = 0;
		hold_requests      = 0;
		idle_cycles        = 0;
		bursts_on          = 1'b1;
		repeat (4) @(posedge clk);
		arst_n = 1'b1;

		// Reset settings first: one label of value zero and all-zero addresses.
		stamps_pending.push_back(64'd0);
		stamps_pending.push_back({64{1'b1}});
		wait_drained();

		// Every register at its top value.
		write_all_regs({60{1'b1}}, {60{1'b1}}, {60{1'b1}}, {60{1'b1}}, {60{1'b1}},
			60'd3, {60{1'b1}});
		stamps_pending.push_back(64'd0);
		stamps_pending.push_back({64{1'b1}});
		stamps_pending.push_back(64'h5555_5555_5555_5555);
		stamps_pending.push_back(64'hAAAA_AAAA_AAAA_AAAA);
		stamps_pending.push_back(64'h0123_4567_89AB_CDEF);
		stamps_pending.push_back(64'h8000_0000_0000_0000);
		stamps_pending.push_back(64'd1);
		wait_drained();

		// A zero label count must behave as a single label.
		write_all_regs('0, '0, '0, '0, '0, 60'd0, 60'h0_0000_0000_FFFFF);
		stamps_pending.push_back(64'd0);
		stamps_pending.push_back({64{1'b1}});
		stamps_pending.push_back(random_stamp());
		wait_drained();

		write_all_regs(random_word(), random_word(), random_word(), random_word(),
			random_word(), 60'd2, random_word());
		repeat (4)
			stamps_pending.push_back(random_stamp());
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_all_regs(random_word(), random_word(), random_word(), random_word(),
				random_word(), 60'($urandom_range(0, 3)), random_word());
			// The closing phase runs with both sides always willing.
			if (p == RANDOM_PHASES - 1)
				bursts_on = 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++)
				stamps_pending.push_back(random_stamp());
			// One long receiver hold while a full phase of items waits to go in.
			if (p == 2)
				hold_requests = hold_requests + 1;
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (frame_words_due.size() != 0) begin
			$error("%0d frame words still expected at the end", frame_words_due.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
